@@ hw/rtl/mcmf_pkg.sv @@
// ---------------------------------------------------------------------------
// mcmf_pkg
// Shared sizes, codes, payload types and control structs for the
// multi-channel mailbox FIFO.
// ---------------------------------------------------------------------------
package mcmf_pkg;

  // Bank sizing
  localparam int BOX_COUNT    = 8;
  localparam int BOX_DEPTH    = 8;
  localparam int MESSAGE_BITS = 32;

  // Fixed payload widths
  localparam int MODE_W = 2;
  localparam int BOXID_W = 4;
  localparam int MSG_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 4;

  // Derived widths
  localparam int STORE_W   = (MESSAGE_BITS < MSG_W) ? MESSAGE_BITS : MSG_W;
  localparam int BOX_IW    = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;
  localparam int IDX_W     = $clog2(BOX_DEPTH);
  localparam int CNT_W     = $clog2(BOX_DEPTH + 1);
  localparam int RAM_DEPTH = BOX_COUNT * BOX_DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_BOX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [BOXID_W-1:0] box_id;
    logic [MSG_W-1:0]   message;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [MSG_W-1:0]  popped_message;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted item
    logic exec;     // commit the operation on the addressed mailbox
    logic finish;   // load the pop result from the message store
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop_hit;  // held item is a pop that will read the store
    logic out_free; // output register can take a result this cycle
  } dp_stat_t;

  // Advance a ring index, wrapping at the depth
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(BOX_DEPTH - 1)) res = '0;
    else                              res = idx + 1'b1;
    return res;
  endfunction

endpackage

@@ hw/rtl/mcmf_ram.sv @@
// ---------------------------------------------------------------------------
// mcmf_ram
// Generic single-write, single-read RAM with a registered read port.
// Read data holds until the next read enable.
// ---------------------------------------------------------------------------
module mcmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/mcmf_ctrl.sv @@
// ---------------------------------------------------------------------------
// mcmf_ctrl
// Sequencer for one mailbox operation: take an item, execute it on the
// addressed mailbox, and for a successful pop wait one store read before the result.
// ---------------------------------------------------------------------------
module mcmf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcmf_pkg::dp_stat_t stat,
  output mcmf_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.pop_hit) begin
          cmd.exec  = 1'b1;
          state_nxt = S_POP;
        end else if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/mcmf_dp.sv @@
// ---------------------------------------------------------------------------
// mcmf_dp
// Mailbox datapath: held item, per-mailbox count and ring indices, the
// shared message store and the result register.
// ---------------------------------------------------------------------------
module mcmf_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mcmf_pkg::in_item_t  in_data,
  input  mcmf_pkg::dp_cmd_t   cmd,
  output mcmf_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output mcmf_pkg::out_item_t out_data
);

  mcmf_pkg::in_item_t item_r;

  logic [mcmf_pkg::CNT_W-1:0] fill_r   [mcmf_pkg::BOX_COUNT];
  logic [mcmf_pkg::IDX_W-1:0] wr_idx_r [mcmf_pkg::BOX_COUNT];
  logic [mcmf_pkg::IDX_W-1:0] rd_idx_r [mcmf_pkg::BOX_COUNT];

  logic [mcmf_pkg::OCC_W-1:0] pend_occ_r;
  logic                       out_valid_r;
  mcmf_pkg::out_item_t        out_data_r;

  logic [mcmf_pkg::BOX_IW-1:0] bidx;
  logic                        box_ok;
  logic [mcmf_pkg::CNT_W-1:0]  cur_cnt, cnt_nxt;
  logic [mcmf_pkg::IDX_W-1:0]  cur_wi, wi_nxt, cur_ri, ri_nxt;
  logic [mcmf_pkg::STAT_W-1:0] res_status;
  logic [mcmf_pkg::OCC_W-1:0]  res_occ;
  logic                        do_write, do_read;
  logic [mcmf_pkg::ADDR_W-1:0] wr_addr, rd_addr;
  logic [mcmf_pkg::STORE_W-1:0] rd_data;
  logic                        out_free;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
  end

  // Look up the addressed mailbox
  assign box_ok  = ({1'b0, item_r.box_id} < (mcmf_pkg::BOXID_W + 1)'(mcmf_pkg::BOX_COUNT));
  assign bidx    = item_r.box_id[mcmf_pkg::BOX_IW-1:0];
  assign cur_cnt = fill_r[bidx];
  assign cur_wi  = wr_idx_r[bidx];
  assign cur_ri  = rd_idx_r[bidx];

  // Decode the operation and work out the new mailbox state
  always_comb begin
    res_status = mcmf_pkg::ST_OK;
    cnt_nxt    = cur_cnt;
    wi_nxt     = cur_wi;
    ri_nxt     = cur_ri;
    do_write   = 1'b0;
    do_read    = 1'b0;
    if (!box_ok) begin
      res_status = mcmf_pkg::ST_NO_BOX;
    end else begin
      unique case (item_r.mode)
        mcmf_pkg::MODE_CLEAR: begin
          cnt_nxt = '0;
          wi_nxt  = '0;
          ri_nxt  = '0;
        end
        mcmf_pkg::MODE_PUSH: begin
          if (cur_cnt == mcmf_pkg::CNT_W'(mcmf_pkg::BOX_DEPTH)) begin
            res_status = mcmf_pkg::ST_FULL;
          end else begin
            do_write = 1'b1;
            wi_nxt   = mcmf_pkg::next_slot(cur_wi);
            cnt_nxt  = cur_cnt + 1'b1;
          end
        end
        mcmf_pkg::MODE_POP: begin
          if (cur_cnt == '0) begin
            res_status = mcmf_pkg::ST_EMPTY;
          end else begin
            do_read = 1'b1;
            ri_nxt  = mcmf_pkg::next_slot(cur_ri);
            cnt_nxt = cur_cnt - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_occ = box_ok ? mcmf_pkg::OCC_W'(cnt_nxt) : '0;

  // Commit the mailbox state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < mcmf_pkg::BOX_COUNT; b++) begin
        fill_r[b]   <= '0;
        wr_idx_r[b] <= '0;
        rd_idx_r[b] <= '0;
      end
    end else if (cmd.exec && box_ok) begin
      fill_r[bidx]   <= cnt_nxt;
      wr_idx_r[bidx] <= wi_nxt;
      rd_idx_r[bidx] <= ri_nxt;
    end
  end

  // Message store addressing
  assign wr_addr = mcmf_pkg::ADDR_W'(mcmf_pkg::ADDR_W'(bidx) *
                   mcmf_pkg::ADDR_W'(mcmf_pkg::BOX_DEPTH) + mcmf_pkg::ADDR_W'(cur_wi));
  assign rd_addr = mcmf_pkg::ADDR_W'(mcmf_pkg::ADDR_W'(bidx) *
                   mcmf_pkg::ADDR_W'(mcmf_pkg::BOX_DEPTH) + mcmf_pkg::ADDR_W'(cur_ri));

  mcmf_ram #(
    .WIDTH (mcmf_pkg::STORE_W),
    .DEPTH (mcmf_pkg::RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.exec && do_write),
    .wr_addr (wr_addr),
    .wr_data (mcmf_pkg::STORE_W'(item_r.message)),
    .rd_en   (cmd.exec && do_read),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Keep the pop occupancy until the store read returns
  always_ff @(posedge clk) begin
    if (cmd.exec && do_read) begin
      pend_occ_r <= res_occ;
    end
  end

  // Result register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.exec && !do_read) || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && !do_read) begin
      out_data_r.status         <= res_status;
      out_data_r.popped_message <= '0;
      out_data_r.occupancy      <= res_occ;
    end else if (cmd.finish) begin
      out_data_r.status         <= mcmf_pkg::ST_OK;
      out_data_r.popped_message <= mcmf_pkg::MSG_W'(rd_data);
      out_data_r.occupancy      <= pend_occ_r;
    end
  end

  assign stat.pop_hit  = do_read;
  assign stat.out_free = out_free;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

@@ hw/rtl/multi_channel_mailbox_fifo_core.sv @@
// ---------------------------------------------------------------------------
// multi_channel_mailbox_fifo_core
// Bank of independent mailboxes, each a circular message FIFO with its own
// count and ring indices; items clear, push into or pop from one mailbox.
// ---------------------------------------------------------------------------
//
//   Channel  Dir  Handshake           Payload
//   in_      in   in_valid/in_stall   in_item_t  (mode, box_id, message)
//   out_     out  out_valid/out_stall out_item_t (status, popped_message,
//                                                 occupancy)
//
// An item passes the accept and execute steps; a successful pop adds a pop
// step for the registered read port of the shared message store.
// The next item is accepted in the cycle after its predecessor completes.
// A held result in the output register does not block acceptance; a new
// result waits in the execute or pop step while the output register holds
// a result that out_stall keeps from leaving.
// Reset clears every mailbox count and index at once; stored messages are
// not cleared.
// ---------------------------------------------------------------------------
module multi_channel_mailbox_fifo_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcmf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mcmf_pkg::out_item_t out_data
);

  mcmf_pkg::dp_cmd_t  cmd;
  mcmf_pkg::dp_stat_t stat;

  mcmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcmf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // One item in flight: an accepted item blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous item in flight");

  // Rejected mailbox number reports nothing
  a_no_box_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == mcmf_pkg::ST_NO_BOX) |->
      (out_data.occupancy == '0) && (out_data.popped_message == '0))
    else $error("no-such-mailbox result carries data");

  // Empty pop reports an empty mailbox
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == mcmf_pkg::ST_EMPTY) |->
      (out_data.occupancy == '0) && (out_data.popped_message == '0))
    else $error("empty result with nonzero occupancy or message");

  // Full push reports a full mailbox
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == mcmf_pkg::ST_FULL) |->
      (out_data.occupancy == mcmf_pkg::OCC_W'(mcmf_pkg::BOX_DEPTH)))
    else $error("full result with wrong occupancy");

endmodule

@@ verif/multi_channel_mailbox_fifo_core_test.sv @@
// ---------------------------------------------------------------------------
// multi_channel_mailbox_fifo_core_test
// Self-checking bench for the mailbox bank. A shadow copy of every mailbox
// (fill, ring pointers, stored words) predicts each result as its item is
// accepted; a monitor compares each returned item, field by field, against
// the oldest prediction. Directed items cover the word extremes, unknown
// mailboxes, the spare mode, full and empty mailboxes and pointer wrap.
// Random bursts then aim mostly at one mailbox, leaning towards fill or drain,
// with random gaps on the sender and random stalls on the receiver.
// ---------------------------------------------------------------------------
module multi_channel_mailbox_fifo_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcmf_pkg::*;

  // Spare mode encoding: no operation, reports the occupancy
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Shadow mailbox bank
  logic [CNT_W-1:0]   box_fill  [BOX_COUNT];
  logic [IDX_W-1:0]   box_wr    [BOX_COUNT];
  logic [IDX_W-1:0]   box_rd    [BOX_COUNT];
  logic [STORE_W-1:0] box_words [BOX_COUNT][BOX_DEPTH];

  out_item_t pending_results[$];

  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned push_ok = 0, pop_ok = 0, full_hits = 0, empty_hits = 0;
  int unsigned bad_box_hits = 0, clears = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  multi_channel_mailbox_fifo_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Mostly no idling, often a short gap, now and then a long stretch
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Apply one item to the shadow bank and return the result it should give
  function automatic out_item_t mailbox_predict(input in_item_t req);
    out_item_t  res;
    int         b;
    res = '0;
    b = req.box_id;
    if (b >= BOX_COUNT) begin
      res.status = ST_NO_BOX;
      bad_box_hits++;
      return res;
    end
    case (req.mode)
      MODE_CLEAR: begin
        box_fill[b] = '0;
        box_wr[b]   = '0;
        box_rd[b]   = '0;
        clears++;
      end
      MODE_PUSH: begin
        if (box_fill[b] >= BOX_DEPTH) begin
          res.status = ST_FULL;
          full_hits++;
        end else begin
          box_words[b][box_wr[b]] = req.message[STORE_W-1:0];
          box_wr[b] = (box_wr[b] == IDX_W'(BOX_DEPTH - 1)) ? '0 : box_wr[b] + 1'b1;
          box_fill[b] = box_fill[b] + 1'b1;
          push_ok++;
        end
      end
      MODE_POP: begin
        if (box_fill[b] == 0) begin
          res.status = ST_EMPTY;
          empty_hits++;
        end else begin
          res.popped_message = MSG_W'(box_words[b][box_rd[b]]);
          box_rd[b] = (box_rd[b] == IDX_W'(BOX_DEPTH - 1)) ? '0 : box_rd[b] + 1'b1;
          box_fill[b] = box_fill[b] - 1'b1;
          pop_ok++;
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(box_fill[b]);
    return res;
  endfunction

  // Offer one item, hold it until accepted, then record its prediction
  task automatic send_request(input logic [MODE_W-1:0] mode, input int box,
                              input logic [MSG_W-1:0] word);
    in_item_t    req;
    int unsigned gap;
    req.mode    = mode;
    req.box_id  = BOXID_W'(box);
    req.message = word;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(mailbox_predict(req));
    items_sent++;
    gap = calm ? 0 : pick_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random item aimed mostly at one mailbox, leaning towards fill or drain
  function automatic in_item_t random_request(input int focus, input bit filling);
    in_item_t    req;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8 && BOX_COUNT < 16) req.box_id = BOXID_W'($urandom_range(BOX_COUNT, 15));
    else if (r < 20)             req.box_id = BOXID_W'($urandom_range(0, BOX_COUNT - 1));
    else                         req.box_id = BOXID_W'(focus);
    r = $urandom_range(0, 99);
    if (r < 3)      req.mode = MODE_SPARE;
    else if (r < 6) req.mode = MODE_CLEAR;
    else if ($urandom_range(0, 99) < (filling ? 75 : 25)) req.mode = MODE_PUSH;
    else            req.mode = MODE_POP;
    req.message = $urandom;
    return req;
  endfunction

  // Word extremes through one mailbox, spare mode, pop from empty, clear
  task automatic test_message_extremes();
    send_request(MODE_PUSH, 0, '0);
    send_request(MODE_PUSH, 0, '1);
    send_request(MODE_SPARE, 0, $urandom);
    send_request(MODE_POP, 0, $urandom);
    send_request(MODE_POP, 0, $urandom);
    send_request(MODE_POP, 0, $urandom);
    send_request(MODE_PUSH, 1, 32'h8000_0001);
    send_request(MODE_CLEAR, 1, $urandom);
    send_request(MODE_POP, 1, $urandom);
  endtask

  // Mailbox numbers past the bank, with every mode
  task automatic test_unknown_mailbox();
    send_request(MODE_PUSH, 15, $urandom);
    send_request(MODE_POP, BOX_COUNT, $urandom);
    send_request(MODE_CLEAR, 9, $urandom);
    send_request(MODE_SPARE, 12, $urandom);
  endtask

  // Fill the last mailbox, push once more, pop and push across the wrap, then clear
  task automatic test_full_and_wrap();
    for (int i = 0; i < BOX_DEPTH; i++)
      send_request(MODE_PUSH, BOX_COUNT - 1, $urandom);
    send_request(MODE_PUSH, BOX_COUNT - 1, $urandom);
    send_request(MODE_POP, BOX_COUNT - 1, $urandom);
    send_request(MODE_PUSH, BOX_COUNT - 1, $urandom);
    send_request(MODE_POP, BOX_COUNT - 1, $urandom);
    send_request(MODE_CLEAR, BOX_COUNT - 1, $urandom);
    send_request(MODE_POP, BOX_COUNT - 1, $urandom);
  endtask

  // Random bursts per mailbox; optionally with no idling on either side
  task automatic test_random_traffic(input int count, input bit no_idle);
    in_item_t req;
    int       focus;
    bit       filling;
    int       burst;
    calm = no_idle;
    burst = 0;
    focus = 0;
    filling = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        focus   = $urandom_range(0, BOX_COUNT - 1);
        filling = $urandom_range(0, 1);
        burst   = $urandom_range(4, 24);
      end
      burst--;
      req = random_request(focus, filling);
      send_request(req.mode, req.box_id, req.message);
    end
    calm = 1'b0;
  endtask

  // Receiver stalls in runs of random length
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= pick_idle();
    end
  end

  function automatic void check_field(input string name, input logic [MSG_W-1:0] want,
                                      input logic [MSG_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each returned item with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0d word 0x%0h occ %0d",
                 $time, out_data.status, out_data.popped_message, out_data.occupancy);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", MSG_W'(want.status), MSG_W'(out_data.status));
        check_field("popped_message", want.popped_message, out_data.popped_message);
        check_field("occupancy", MSG_W'(want.occupancy), MSG_W'(out_data.occupancy));
        results_checked++;
      end
    end
  end

  // Abort if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    for (int b = 0; b < BOX_COUNT; b++) begin
      box_fill[b] = '0;
      box_wr[b]   = '0;
      box_rd[b]   = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_message_extremes();
    test_unknown_mailbox();
    test_full_and_wrap();
    test_random_traffic(200, 1'b1);
    test_random_traffic(1000, 1'b0);

    // Drain what is still in flight
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, checked %0d results, %0d field mismatches.",
             items_sent, results_checked, mismatches);
    $display("Pushes %0d, pops %0d, full %0d, empty %0d, unknown mailbox %0d, clears %0d.",
             push_ok, pop_ok, full_hits, empty_hits, bad_box_hits, clears);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
